[rtl/bblp_pkg.sv]
// shared types and constants of the horizontal box blur line pass
package bblp_pkg;

	localparam int PIX_W      = 32;
	localparam int CH_N       = 4;
	localparam int CH_BITS    = 8;
	localparam int SUM_W      = 15;
	localparam int HW_W       = 6;
	localparam int RING_AW    = 7;
	localparam int RING_DEPTH = 1 << RING_AW;
	localparam int DIV_STEPS  = CH_BITS;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [HW_W-1:0] MAX_HALF_WIDTH = 6'd63;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             line_end;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             line_done;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // take the input pixel
		logic start;     // clear sums and window index
		logic issue;     // read one window position
		logic div_init;  // load dividers
		logic div_step;  // one quotient bit
		logic next_out;  // result taken, move to next flush position
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_out;
		logic rd_last;
		logic div_last;
		logic more_out;
	} dp_status_t;

endpackage

[rtl/bblp_dp.sv]
// datapath: pixel ring, window sums, per-channel restoring dividers with a shared divisor, result register
module bblp_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bblp_pkg::dp_cmd_t              cmd,
	output bblp_pkg::dp_status_t           status,
	input  bblp_pkg::in_item_t             in_data,
	input  logic                           cfg_valid,
	input  logic [bblp_pkg::HW_W-1:0]      cfg_data,
	output bblp_pkg::out_item_t            out_data
);
	import bblp_pkg::*;

	logic [PIX_W-1:0]   ring_mem [RING_DEPTH];
	logic [HW_W-1:0]    half_width_q, line_hw_q, ob_q, hw_eff, hw_sat, ob_init;
	logic [RING_AW-1:0] ring_wr_q, wr_ptr_nxt, pix_seen_q, n_q, j_q, back_c, rd_addr;
	logic [PIX_W-1:0]   edge_q, rd_data_s1, acc_pix;
	logic               rd_vld_s1, use_edge, use_edge_s1, last_q;
	logic [RING_AW:0]   back_raw;
	logic [SUM_W-1:0]   sums_q [CH_N];
	logic [SUM_W-1:0]   rem_q [CH_N];
	logic [SUM_W-1:0]   dsh_q;
	logic [CH_BITS-1:0] quot_q [CH_N];
	logic [STEP_W-1:0]  step_q;

	// half width is latched at the first pixel of a line
	assign hw_sat     = (half_width_q > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : half_width_q;
	assign hw_eff     = (pix_seen_q == '0) ? hw_sat : line_hw_q;
	assign ob_init    = (in_data.line_end && (pix_seen_q < RING_AW'(hw_eff)))
		? pix_seen_q[HW_W-1:0] : hw_eff;
	assign wr_ptr_nxt = ring_wr_q + 1'b1;

	// distance back from newest pixel, may go negative on the right edge
	assign back_raw = {2'b00, ob_q} + {2'b00, line_hw_q} - {1'b0, j_q};
	assign back_c   = back_raw[RING_AW] ? '0 : back_raw[RING_AW-1:0];
	assign use_edge = !back_raw[RING_AW] && (back_raw[RING_AW-1:0] > n_q);
	assign rd_addr  = ring_wr_q - back_c;
	assign acc_pix  = use_edge_s1 ? edge_q : rd_data_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_mem[wr_ptr_nxt] <= in_data.pixel_in;
		end
		if (cmd.issue) begin
			rd_data_s1  <= ring_mem[rd_addr];
			use_edge_s1 <= use_edge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HW_W'(1);
			line_hw_q    <= '0;
			ring_wr_q    <= '0;
			pix_seen_q   <= '0;
			edge_q       <= '0;
			n_q          <= '0;
			last_q       <= 1'b0;
			ob_q         <= '0;
			j_q          <= '0;
			rd_vld_s1    <= 1'b0;
			step_q       <= '0;
		end else begin
			if (cfg_valid) begin
				half_width_q <= cfg_data;
			end
			rd_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				ring_wr_q <= wr_ptr_nxt;
				line_hw_q <= hw_eff;
				n_q       <= pix_seen_q;
				last_q    <= in_data.line_end;
				ob_q      <= ob_init;
				if (pix_seen_q == '0) begin
					edge_q <= in_data.pixel_in;
				end
				if (in_data.line_end) begin
					pix_seen_q <= '0;
				end else if (pix_seen_q != '1) begin
					pix_seen_q <= pix_seen_q + 1'b1;
				end
			end
			if (cmd.start) begin
				j_q <= '0;
			end else if (cmd.issue) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.next_out) begin
				ob_q <= ob_q - 1'b1;
			end
		end
	end

	// per channel accumulate, then restoring division by 2h+1
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dsh_q <= SUM_W'({line_hw_q, 1'b1}) << (DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
		end
		for (int c = 0; c < CH_N; c++) begin
			if (cmd.start) begin
				sums_q[c] <= '0;
			end else if (rd_vld_s1) begin
				sums_q[c] <= sums_q[c] + SUM_W'(acc_pix[c*CH_BITS +: CH_BITS]);
			end
			if (cmd.div_init) begin
				rem_q[c] <= sums_q[c] + SUM_W'(line_hw_q);
			end else if (cmd.div_step) begin
				if (rem_q[c] >= dsh_q) begin
					rem_q[c]  <= rem_q[c] - dsh_q;
					quot_q[c] <= {quot_q[c][CH_BITS-2:0], 1'b1};
				end else begin
					quot_q[c] <= {quot_q[c][CH_BITS-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			out_data.pixel_out[c*CH_BITS +: CH_BITS] = quot_q[c];
		end
		out_data.line_done = last_q && (ob_q == '0);
	end

	assign status.has_out  = last_q || (n_q >= RING_AW'(line_hw_q));
	assign status.rd_last  = (j_q == {line_hw_q, 1'b0});
	assign status.div_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign status.more_out = last_q && (ob_q != '0);

	a_no_lost_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> !rd_vld_s1)
		else $error("divider loaded while a window read is still in flight");

	a_edge_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (pix_seen_q == '0)) |=> (edge_q == $past(in_data.pixel_in)))
		else $error("first pixel of line not captured as edge pixel");

	a_hw_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && (pix_seen_q != '0)) |=> (line_hw_q == $past(line_hw_q)))
		else $error("half width changed inside a line");

endmodule

[rtl/bblp_ctrl.sv]
// controller: sequences load, window reads, division and result handshake
module bblp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bblp_pkg::dp_cmd_t    cmd,
	input  bblp_pkg::dp_status_t status
);
	import bblp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_CHECK   = 7'b0000010,
		S_READ    = 7'b0000100,
		S_ACC     = 7'b0001000,
		S_DIVINIT = 7'b0010000,
		S_DIV     = 7'b0100000,
		S_OUT     = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.load     = in_valid && in_ready;
		cmd.issue    = (state_q == S_READ);
		cmd.div_init = (state_q == S_DIVINIT);
		cmd.div_step = (state_q == S_DIV);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.has_out) begin
					cmd.start = 1'b1;
					state_nxt = S_READ;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_READ: begin
				if (status.rd_last) begin
					state_nxt = S_ACC;
				end
			end
			S_ACC: begin
				state_nxt = S_DIVINIT;
			end
			S_DIVINIT: begin
				state_nxt = S_DIV;
			end
			S_DIV: begin
				if (status.div_last) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.next_out = 1'b1;
					state_nxt    = status.more_out ? S_CHECK : S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVINIT) |=> ##(DIV_STEPS) (state_q == S_OUT))
		else $error("division did not take the expected number of steps");

	a_flush_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && status.more_out) |=> (state_q == S_CHECK))
		else $error("pending flush output dropped");

endmodule

[rtl/box_blur_line_pass_top.sv]
// top level of the horizontal box blur line pass
// usage:
//   in channel (in_valid/in_ready/in_data) takes one packed rgba pixel per
//   transaction, line_end set on the last pixel of a line
//   out channel (out_valid/out_ready/out_data) gives blurred pixels in line
//   order, line_done set on the last one of the line
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the half width h;
//   it is always ready and is sampled at the first pixel of each line
// sequencing:
//   one item is worked at a time; in_ready is high only when idle
//   a pixel with no result due passes only through accept and check
//   a pixel with a result due holds the block through accept, check,
//   2h+1 ring reads, accumulate, divider load, 8 divider steps and the
//   output state, plus receiver wait
//   a line_end pixel emits min(n,h)+1 results; each after the first
//   repeats the sequence from check on, with no accept, plus receiver wait
// reset: arst_n clears the line state; h resets to 1; the ring holds
//   garbage until written but only written entries are ever read
// stall: the result stays on out_data with out_valid high until taken,
//   and no new pixel is accepted meanwhile
module box_blur_line_pass_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bblp_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bblp_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bblp_pkg::HW_W-1:0]  cfg_data
);
	import bblp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// the half width register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// state machine: handshakes and sequencing
	bblp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// pixel ring, sums, dividers and result register
	bblp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

[verif/box_blur_line_pass_check.sv]
// checker for the box blur line pass: predicts blurred pixels and compares them
module box_blur_line_pass_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  bblp_pkg::in_item_t           in_data,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  bblp_pkg::out_item_t          out_data,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [bblp_pkg::HW_W-1:0]    cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import bblp_pkg::*;

	logic [PIX_W-1:0]   line_ring [RING_DEPTH];
	logic [RING_AW-1:0] wr_ptr;
	logic [RING_AW-1:0] seen;
	logic [HW_W-1:0]    hw_reg;
	logic [HW_W-1:0]    line_hw;
	logic [PIX_W-1:0]   first_px;
	out_item_t          blurred_due [$];
	out_item_t          want;

	// pixel at line position n - back, clamped to the line edges
	function automatic logic [PIX_W-1:0] line_pixel(input int back, input int n);
		int b;
		b = (back < 0) ? 0 : back;
		if (b > n)
			return first_px;
		return line_ring[(int'(wr_ptr) - b) & (RING_DEPTH - 1)];
	endfunction

	// rounded per-channel mean around output position n - ob
	function automatic logic [PIX_W-1:0] box_mean(input int ob, input int n);
		int h;
		int sums [CH_N];
		logic [PIX_W-1:0] p;
		logic [PIX_W-1:0] mean;
		h = int'(line_hw);
		mean = '0;
		for (int c = 0; c < CH_N; c++)
			sums[c] = 0;
		for (int k = -h; k <= h; k++) begin
			p = line_pixel(ob - k, n);
			for (int c = 0; c < CH_N; c++)
				sums[c] += int'(p[CH_BITS*c +: CH_BITS]);
		end
		for (int c = 0; c < CH_N; c++)
			mean[CH_BITS*c +: CH_BITS] = CH_BITS'((sums[c] + h) / (2 * h + 1));
		return mean;
	endfunction

	task automatic take_pixel(input in_item_t t);
		int n;
		int h;
		int ob;
		out_item_t r;
		n = int'(seen);
		if (n == 0) begin
			line_hw = (hw_reg > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : hw_reg;
			first_px = t.pixel_in;
		end
		wr_ptr = wr_ptr + 1'b1;
		line_ring[wr_ptr] = t.pixel_in;
		h = int'(line_hw);
		if (!t.line_end) begin
			if (n >= h) begin
				r.pixel_out = box_mean(h, n);
				r.line_done = 1'b0;
				blurred_due.push_back(r);
			end
			if (seen != {RING_AW{1'b1}})
				seen = seen + 1'b1;
		end else begin
			// flush every pending output, oldest first
			ob = (n < h) ? n : h;
			while (ob >= 0) begin
				r.pixel_out = box_mean(ob, n);
				r.line_done = (ob == 0);
				blurred_due.push_back(r);
				ob--;
			end
			seen = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = '0;
			seen = '0;
			hw_reg = HW_W'(1);
			line_hw = '0;
			first_px = '0;
			blurred_due.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			// a pixel taken at the same edge as a write still sees the old width
			if (in_valid && in_ready)
				take_pixel(in_data);
			if (cfg_valid && cfg_ready)
				hw_reg = cfg_data;
			if (out_valid && out_ready) begin
				if (blurred_due.size() == 0) begin
					$error("unexpected result: pixel_out %h line_done %b",
						out_data.pixel_out, out_data.line_done);
					fail_count++;
				end else begin
					want = blurred_due.pop_front();
					checked++;
					if (out_data.pixel_out !== want.pixel_out) begin
						$error("pixel_out: expected %h, got %h",
							want.pixel_out, out_data.pixel_out);
						fail_count++;
					end
					if (out_data.line_done !== want.line_done) begin
						$error("line_done: expected %b, got %b",
							want.line_done, out_data.line_done);
						fail_count++;
					end
				end
			end
			pending = blurred_due.size();
		end
	end

endmodule

[verif/box_blur_line_pass_top_test.sv]
// stimulus, idling and verdict for the box blur line pass testbench
module box_blur_line_pass_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bblp_pkg::*;

	// cycles with no transaction before the run is called hung; the slowest
	// legal gap is the long receiver hold plus one widest-window result
	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;
	// a pixel with no result due keeps the block busy through accept and check
	localparam int SETTLE_CYCLES = 4;
	// one widest-window result takes 2*63+1 ring reads plus the divider sequence
	localparam int TAIL_CYCLES   = 150;
	localparam int ITEM_TARGET   = 370;
	localparam int CALM_FROM     = 320;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [HW_W-1:0]   cfg_data = '0;

	int fail_count;
	int pending;
	int checked;

	int pixels_sent = 0;
	int lines_sent = 0;
	int hw_writes = 0;
	int widest = 1;
	int reg_hw = 1;      // mirror of the half width register
	int quiet = 0;
	bit calm = 1'b0;     // no more idling on either side
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	box_blur_line_pass_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	box_blur_line_pass_check blur_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, giving up", quiet);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random ready stretches and stall bursts, one long hold on
	// request so the block backs up and stops taking pixels
	initial begin
		int stretch;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				stretch = HOLD_CYCLES;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				stretch = $urandom_range(1, 16);
			end else begin
				out_ready <= 1'b1;
				stretch = calm ? 1 : $urandom_range(1, 24);
			end
			repeat (stretch) @(negedge clk);
		end
	end

	// random pixel, biased toward the channel extremes
	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] v;
		v = '0;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: begin
				for (int c = 0; c < CH_N; c++)
					v[CH_BITS*c +: CH_BITS] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// one pixel transaction; called at a falling edge, returns at one with
	// valid still high so a following pixel can go out with no gap
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last);
		in_item_t t;
		t.pixel_in = px;
		t.line_end = last;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_data <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		if (last)
			lines_sent++;
		calm = (pixels_sent >= CALM_FROM);
		@(negedge clk);
	endtask

	// drop valid and wait for every expected pixel, then let the block settle
	task automatic quiet_down(input int extra);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_half_width(input logic [HW_W-1:0] v);
		quiet_down(SETTLE_CYCLES);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_hw = int'(v);
		hw_writes++;
		if (int'(v) > widest)
			widest = int'(v);
	endtask

	// one line of random pixels; cfg_at >= 0 rewrites the register after that
	// pixel, which must only take effect from the next line
	task automatic blur_line(input int hw, input int len, input int cfg_at);
		if (hw != reg_hw)
			write_half_width(HW_W'(hw));
		for (int p = 0; p < len; p++) begin
			send_pixel(pick_pixel(), p == len - 1);
			if (p == cfg_at)
				write_half_width(HW_W'($urandom_range(0, int'(MAX_HALF_WIDTH))));
		end
	endtask

	initial begin
		int hw;
		int len;
		int cfg_at;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset half width of one, black, white and mixed channels
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h80FF_007F, 1'b1);
		// line of a single pixel
		send_pixel(32'hFFFF_FFFF, 1'b1);

		// zero half width: each pixel passes through unchanged
		write_half_width('0);
		send_pixel(32'h1234_5678, 1'b0);
		send_pixel(32'hFEDC_BA98, 1'b0);
		send_pixel(32'h0000_0001, 1'b1);

		// widest window on a line far shorter than it: edges on both sides
		write_half_width(MAX_HALF_WIDTH);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h0101_0101, 1'b1);

		// register rewritten mid-line: this line keeps two, the next gets five
		write_half_width(HW_W'(2));
		send_pixel(32'hFF00_FF00, 1'b0);
		send_pixel(32'h00FF_00FF, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		write_half_width(HW_W'(5));
		send_pixel(32'h7F7F_7F7F, 1'b0);
		send_pixel(32'h8080_8080, 1'b0);
		send_pixel(32'h0000_0000, 1'b1);
		blur_line(5, 5, -1);

		// receiver goes quiet for a long stretch while pixels keep coming;
		// the width is set first so the hold falls inside the line
		write_half_width(HW_W'(2));
		hold_req = 1'b1;
		blur_line(2, 24, -1);

		// line longer than the ring, so the pixel count saturates
		blur_line($urandom_range(0, int'(MAX_HALF_WIDTH)), $urandom_range(130, 140), -1);

		while (pixels_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: hw = $urandom_range(0, 3);
				5, 6, 7:       hw = $urandom_range(4, 15);
				default:       hw = $urandom_range(16, int'(MAX_HALF_WIDTH));
			endcase
			// often keep the width so lines stream back to back
			if ($urandom_range(0, 2) == 0)
				hw = reg_hw;
			case ($urandom_range(0, 4))
				0:       len = $urandom_range(1, 3);
				1, 2:    len = $urandom_range(1, (2 * hw + 6 > 40) ? 40 : 2 * hw + 6);
				default: len = $urandom_range(4, 40);
			endcase
			if (len > 2 && $urandom_range(0, 5) == 0)
				cfg_at = $urandom_range(0, len - 2);
			else
				cfg_at = -1;
			blur_line(hw, len, cfg_at);
		end

		quiet_down(TAIL_CYCLES);

		$display("ran %0d pixels in %0d lines, %0d blurred pixels compared",
			pixels_sent, lines_sent, checked);
		$display("%0d half width writes, widest window %0d pixels, one long output stall",
			hw_writes, 2 * widest + 1);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
